### hdl/tfbat_pkg.sv
// ----------------------------------------------------------------------------
// tfbat_pkg
// Shared types and constants of the tcp flow byte accounting table.
// ----------------------------------------------------------------------------
`default_nettype none

package tfbat_pkg;

    localparam int IN_W      = 120;
    localparam int OUT_W     = 80;
    localparam int USER_W    = 2;
    localparam int KEY_W     = 32;
    localparam int LEN_W     = 16;
    localparam int TOTAL_W   = 32;
    localparam int FLOWS_W   = 9;

    localparam logic [7:0] TCP_PROTOCOL = 8'd6;

    typedef enum logic [1:0]
    {
        OUTCOME_UPDATED = 2'd0,
        OUTCOME_NEW     = 2'd1,
        OUTCOME_IGNORED = 2'd2,
        OUTCOME_FULL    = 2'd3
    } outcome_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_WALK,
        ST_READ,
        ST_ADD,
        ST_RESULT
    } state_t;

    typedef struct packed
    {
        logic               start;
        logic               shift;
        logic               clear;
        logic               write;
        logic [KEY_W-1:0]   key;
        logic [TOTAL_W-1:0] bytes;
    } cell_ctrl_t;

    typedef struct packed
    {
        logic               any_tok;
        logic               any_hit;
        logic               any_free;
        logic [TOTAL_W-1:0] rd_bytes;
    } chain_status_t;

endpackage

`default_nettype wire

### hdl/tfbat_cell.sv
// ----------------------------------------------------------------------------
// tfbat_cell
// One table entry: key, byte total, valid bit and the search token bit.
// ----------------------------------------------------------------------------
`default_nettype none

module tfbat_cell
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 tok_in,
    input  tfbat_pkg::cell_ctrl_t               ctrl,
    output logic                                tok_out,
    output logic                                hit,
    output logic                                free,
    output logic [tfbat_pkg::TOTAL_W-1:0]       rd_bytes
);

    logic                               tok_reg;
    logic                               tok_next;
    logic                               valid_reg;
    logic                               valid_next;
    logic [tfbat_pkg::KEY_W-1:0]        key_reg;
    logic [tfbat_pkg::KEY_W-1:0]        key_next;
    logic [tfbat_pkg::TOTAL_W-1:0]      bytes_reg;
    logic [tfbat_pkg::TOTAL_W-1:0]      bytes_next;

    always_comb
    begin
        tok_next   = tok_reg;
        valid_next = valid_reg;
        key_next   = key_reg;
        bytes_next = bytes_reg;
        if (ctrl.clear)
        begin
            tok_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            tok_next = tok_in;
        end
        if (ctrl.write && tok_reg)
        begin
            valid_next = 1'b1;
            key_next   = ctrl.key;
            bytes_next = ctrl.bytes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            tok_reg   <= tok_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        bytes_reg <= bytes_next;
    end

    assign tok_out  = tok_reg;
    assign hit      = tok_reg & valid_reg & (key_reg == ctrl.key);
    assign free     = tok_reg & ~valid_reg;
    assign rd_bytes = tok_reg ? bytes_reg : '0;

endmodule

`default_nettype wire

### hdl/tfbat_chain.sv
// ----------------------------------------------------------------------------
// tfbat_chain
// Row of table cells; the search token moves one cell per cycle on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module tfbat_chain
#(
    parameter int TABLE_ENTRIES = 256
)
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  tfbat_pkg::cell_ctrl_t       ctrl,
    output tfbat_pkg::chain_status_t    status
);

    logic [TABLE_ENTRIES-1:0]           tok_vec;
    logic [TABLE_ENTRIES-1:0]           hit_vec;
    logic [TABLE_ENTRIES-1:0]           free_vec;
    logic [tfbat_pkg::TOTAL_W-1:0]      rd_arr [TABLE_ENTRIES];
    logic [tfbat_pkg::TOTAL_W-1:0]      rd_acc;

    genvar i;
    generate
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin : g_cell
            logic tok_in;
            if (i == 0)
            begin : g_head
                assign tok_in = ctrl.start;
            end
            else
            begin : g_body
                assign tok_in = tok_vec[i-1];
            end
            tfbat_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .tok_in   (tok_in),
                .ctrl     (ctrl),
                .tok_out  (tok_vec[i]),
                .hit      (hit_vec[i]),
                .free     (free_vec[i]),
                .rd_bytes (rd_arr[i])
            );
        end
    endgenerate

    always_comb
    begin
        rd_acc = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            rd_acc = rd_acc | rd_arr[k];
        end
    end

    assign status.any_tok  = |tok_vec;
    assign status.any_hit  = |hit_vec;
    assign status.any_free = |free_vec;
    assign status.rd_bytes = rd_acc;

endmodule

`default_nettype wire

### hdl/tcp_flow_byte_accounting_table.sv
// ----------------------------------------------------------------------------
// tcp_flow_byte_accounting_table
// Per-flow byte totals of tcp packets, kept in a row of table cells.
// ----------------------------------------------------------------------------
//  channel  dir  contents
//  s_*      in   packet summary: protocol, addresses, ports, length
//  m_*      out  flow key, byte total, active flows; outcome on tuser
//
//  non-tcp packet: from idle straight to the result state, then ready again
//  new flow at entry k: walk to k, write, result; known flow at k: walk, read, add, result
//  full table: reported once the token has walked off the end of the cell row
//  reset clears all entries at once; one packet is worked at a time
//  a result waiting on m_tready holds the block only at its final cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_flow_byte_accounting_table
#(
    parameter int TABLE_ENTRIES = 256
)
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // protocol, source_address, dest_address, source_port, dest_port,
    // packet_length
    input  wire  [tfbat_pkg::IN_W-1:0]          s_tdata,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // flow_key, flow_total, active_flows
    output logic [tfbat_pkg::OUT_W-1:0]         m_tdata,
    // outcome
    output logic [tfbat_pkg::USER_W-1:0]        m_tuser
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    tfbat_pkg::state_t                  state_reg;
    tfbat_pkg::state_t                  state_next;
    logic [tfbat_pkg::KEY_W-1:0]        key_reg;
    logic [tfbat_pkg::KEY_W-1:0]        key_next;
    logic [tfbat_pkg::LEN_W-1:0]        len_reg;
    logic [tfbat_pkg::LEN_W-1:0]        len_next;
    tfbat_pkg::outcome_t                outcome_reg;
    tfbat_pkg::outcome_t                outcome_next;
    logic [tfbat_pkg::TOTAL_W-1:0]      total_reg;
    logic [tfbat_pkg::TOTAL_W-1:0]      total_next;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic                               m_valid_reg;
    logic                               m_valid_next;
    logic [tfbat_pkg::KEY_W-1:0]        m_key_reg;
    logic [tfbat_pkg::KEY_W-1:0]        m_key_next;
    logic [tfbat_pkg::TOTAL_W-1:0]      m_total_reg;
    logic [tfbat_pkg::TOTAL_W-1:0]      m_total_next;
    logic [tfbat_pkg::FLOWS_W-1:0]      m_flows_reg;
    logic [tfbat_pkg::FLOWS_W-1:0]      m_flows_next;
    tfbat_pkg::outcome_t                m_outcome_reg;
    tfbat_pkg::outcome_t                m_outcome_next;

    logic [7:0]                         in_proto;
    logic [31:0]                        in_saddr;
    logic [31:0]                        in_daddr;
    logic [15:0]                        in_sport;
    logic [15:0]                        in_dport;
    logic [tfbat_pkg::LEN_W-1:0]        in_len;
    logic [tfbat_pkg::KEY_W-1:0]        in_key;
    logic [tfbat_pkg::TOTAL_W:0]        sum;
    logic [tfbat_pkg::TOTAL_W-1:0]      sat;
    logic [tfbat_pkg::FLOWS_W-1:0]      flows;

    tfbat_pkg::cell_ctrl_t              ctrl;
    tfbat_pkg::chain_status_t           status;

    assign in_proto = s_tdata[7:0];
    assign in_saddr = s_tdata[39:8];
    assign in_daddr = s_tdata[71:40];
    assign in_sport = s_tdata[87:72];
    assign in_dport = s_tdata[103:88];
    assign in_len   = s_tdata[119:104];
    assign in_key   = in_saddr ^ in_daddr ^ {16'b0, in_sport} ^ {16'b0, in_dport};

    assign sum = {1'b0, total_reg} + {{(tfbat_pkg::TOTAL_W - tfbat_pkg::LEN_W + 1){1'b0}},
                                      len_reg};
    assign sat = sum[tfbat_pkg::TOTAL_W] ? '1 : sum[tfbat_pkg::TOTAL_W-1:0];

    generate
        if (CNT_W >= tfbat_pkg::FLOWS_W)
        begin : g_flows_cut
            assign flows = count_reg[tfbat_pkg::FLOWS_W-1:0];
        end
        else
        begin : g_flows_ext
            assign flows = {{(tfbat_pkg::FLOWS_W - CNT_W){1'b0}}, count_reg};
        end
    endgenerate

    tfbat_chain
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    )
    u_chain
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .status (status)
    );

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        outcome_next   = outcome_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg;
        m_key_next     = m_key_reg;
        m_total_next   = m_total_reg;
        m_flows_next   = m_flows_reg;
        m_outcome_next = m_outcome_reg;
        ctrl           = '0;
        ctrl.key       = key_reg;
        ctrl.bytes     = {{(tfbat_pkg::TOTAL_W - tfbat_pkg::LEN_W){1'b0}}, len_reg};

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            tfbat_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    key_next = in_key;
                    len_next = in_len;
                    if (in_proto == tfbat_pkg::TCP_PROTOCOL)
                    begin
                        ctrl.start = 1'b1;
                        ctrl.shift = 1'b1;
                        state_next = tfbat_pkg::ST_WALK;
                    end
                    else
                    begin
                        outcome_next = tfbat_pkg::OUTCOME_IGNORED;
                        total_next   = '0;
                        state_next   = tfbat_pkg::ST_RESULT;
                    end
                end
            end
            tfbat_pkg::ST_WALK:
            begin
                if (status.any_hit)
                begin
                    state_next = tfbat_pkg::ST_READ;
                end
                else if (status.any_free)
                begin
                    ctrl.write   = 1'b1;
                    ctrl.clear   = 1'b1;
                    count_next   = count_reg + CNT_W'(1);
                    outcome_next = tfbat_pkg::OUTCOME_NEW;
                    total_next   = {{(tfbat_pkg::TOTAL_W - tfbat_pkg::LEN_W){1'b0}}, len_reg};
                    state_next   = tfbat_pkg::ST_RESULT;
                end
                else if (!status.any_tok)
                begin
                    outcome_next = tfbat_pkg::OUTCOME_FULL;
                    total_next   = '0;
                    state_next   = tfbat_pkg::ST_RESULT;
                end
                else
                begin
                    ctrl.shift = 1'b1;
                end
            end
            tfbat_pkg::ST_READ:
            begin
                total_next = status.rd_bytes;
                state_next = tfbat_pkg::ST_ADD;
            end
            tfbat_pkg::ST_ADD:
            begin
                ctrl.write   = 1'b1;
                ctrl.clear   = 1'b1;
                ctrl.bytes   = sat;
                total_next   = sat;
                outcome_next = tfbat_pkg::OUTCOME_UPDATED;
                state_next   = tfbat_pkg::ST_RESULT;
            end
            tfbat_pkg::ST_RESULT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next   = 1'b1;
                    m_key_next     = key_reg;
                    m_total_next   = total_reg;
                    m_flows_next   = flows;
                    m_outcome_next = outcome_reg;
                    state_next     = tfbat_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tfbat_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tfbat_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        len_reg       <= len_next;
        outcome_reg   <= outcome_next;
        total_reg     <= total_next;
        m_key_reg     <= m_key_next;
        m_total_reg   <= m_total_next;
        m_flows_reg   <= m_flows_next;
        m_outcome_reg <= m_outcome_next;
    end

    assign s_tready = (state_reg == tfbat_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_flows_reg, m_total_reg, m_key_reg};
    assign m_tuser  = m_outcome_reg;

endmodule

`default_nettype wire

### hdl/tfbat_checker.sv
// ----------------------------------------------------------------------------
// tfbat_checker
// Port-level checks of the tcp flow byte accounting table.
// ----------------------------------------------------------------------------
`default_nettype none

module tfbat_checker
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    input  wire                                 s_tready,
    input  wire                                 m_tvalid,
    input  wire                                 m_tready,
    input  wire  [tfbat_pkg::OUT_W-1:0]         m_tdata,
    input  wire  [tfbat_pkg::USER_W-1:0]        m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second packet taken while one is in work");

    a_ignored_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == tfbat_pkg::OUTCOME_IGNORED) |-> m_tdata[63:32] == 32'd0)
        else $error("non-tcp packet reports a byte total");

    a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == tfbat_pkg::OUTCOME_FULL) |-> m_tdata[63:32] == 32'd0)
        else $error("dropped packet reports a byte total");

endmodule

bind tcp_flow_byte_accounting_table tfbat_checker u_tfbat_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
